>>> rtl/fmdc_pkg.sv
// ----------------------------------------------------------------------------
// fmdc_pkg
// Shared types, constants and helpers of the fragment map duplicate checker.
// ----------------------------------------------------------------------------
package fmdc_pkg;

  // default map size in fragments
  localparam int MAP_FRAGS_DEF = 65536;

  // field widths
  localparam int ADDR_W  = 24;
  localparam int CNT_W   = 4;
  localparam int FPB_W   = 4;
  localparam int FSC_W   = 17;
  localparam int TOTAL_W = 32;
  localparam int WIN_W   = 16;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAGS_PER_BLOCK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FS_FRAG_COUNT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_RANGE_CHECK = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DUP_CHECK_OFF    = 2'd3;

  // reset values of the registers
  localparam logic [FPB_W-1:0] FPB_RST = 4'd8;
  localparam logic [FSC_W-1:0] FSC_RST = 17'h10000;

  // sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BUSY
  } state_t;

  // decoded claim, held from the read to the write back
  typedef struct packed {
    logic             bad;
    logic             whole;
    logic             mis;
    logic             par;
    logic [FPB_W-1:0] fpb;
    logic [WIN_W-1:0] mask;
  } claim_t;

  // block size: anything but 1, 2 or 4 acts as 8
  function automatic logic [FPB_W-1:0] block_size(input logic [FPB_W-1:0] fpb);
    logic [FPB_W-1:0] res;
    case (fpb)
      4'd1: res = 4'd1;
      4'd2: res = 4'd2;
      4'd4: res = 4'd4;
      default: res = 4'd8;
    endcase
    return res;
  endfunction

endpackage

>>> rtl/fragment_map_duplicate_checker.sv
// ----------------------------------------------------------------------------
// fragment_map_duplicate_checker
// Used-fragment bitmap with duplicate detection for fragment and block claims.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one claim word (first fragment, fragment count), valid/stall.
//   out_*  : one result word per claim (flags, duplicates, running total).
//   cfg_*  : register writes, by user only with no claim in flight; unchecked.
// The bitmap sits in two byte-wide banks (even and odd bytes), so any run of
// up to eight fragments reads one byte of each bank in the same cycle.
// Flow: on accept the claim is registered and both banks are read; the
// fetched bytes are then merged and written back as the result word is
// registered. No new claim is taken until this read-modify-write is done.
// Reset: the banks are swept to zero, one row of both banks per cycle, over
// all ceil(ceil(MAP_FRAGS/8)/2) rows (4096 at the default size); in_stall is
// high during the sweep. Configuration writes are taken during the sweep.
// Stall: while out_stall holds a result, one further claim may be accepted;
// its write back and the total update wait until the output word is taken.
// ----------------------------------------------------------------------------
module fragment_map_duplicate_checker #(
  parameter int MAP_FRAGS = fmdc_pkg::MAP_FRAGS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [fmdc_pkg::ADDR_W-1:0]     in_frag_addr,
  input  logic [fmdc_pkg::CNT_W-1:0]      in_frag_count,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_bad_address,
  output logic [3:0]                      out_dup_count,
  output logic                            out_whole_block_dup,
  output logic                            out_misaligned,
  output logic [fmdc_pkg::TOTAL_W-1:0]    out_total_dup,
  input  logic                            cfg_we,
  input  logic [fmdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fmdc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int MAP_BYTES  = (MAP_FRAGS + 7) / 8;
  localparam int BANK_DEPTH = (MAP_BYTES + 1) / 2;
  localparam int ROW_W      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(BANK_DEPTH - 1);

  // configuration registers
  logic [fmdc_pkg::FPB_W-1:0] fpb_cfg_r;
  logic [fmdc_pkg::FSC_W-1:0] fsc_cfg_r;
  logic                       skip_cfg_r;
  logic                       off_cfg_r;

  // sequencer and claim stage
  fmdc_pkg::state_t state_r, state_nxt;
  logic [ROW_W-1:0] clr_cnt_r, clr_cnt_nxt;
  fmdc_pkg::claim_t claim_r;
  logic             active_r;

  // result registers
  logic                         out_valid_r, out_valid_nxt;
  logic                         bad_r;
  logic [3:0]                   dups_r;
  logic                         wdup_r;
  logic                         mis_r;
  logic [fmdc_pkg::TOTAL_W-1:0] total_r, total_nxt;

  fmdc_pkg::claim_t dec_claim;
  logic [ROW_W-1:0] dec_even_row, dec_odd_row;
  logic [ROW_W-1:0] even_row_r, odd_row_r;

  logic             in_acc;
  logic             rd_en;
  logic             finish;
  logic [7:0]       even_q, odd_q;
  logic [15:0]      win, used, new_win;
  logic             full;
  logic [3:0]       dups;
  logic             wdup;
  logic             mis;
  logic [fmdc_pkg::TOTAL_W:0] total_sum;
  logic             even_we, odd_we;
  logic [ROW_W-1:0] even_wrow, odd_wrow;
  logic [7:0]       even_wdata, odd_wdata;

  function automatic logic [4:0] popcount16(input logic [15:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 16; i++) begin
      n = n + 5'(v[i]);
    end
    return n;
  endfunction

  fmdc_decode #(
    .MAP_FRAGS (MAP_FRAGS)
  ) u_decode (
    .frag_addr        (in_frag_addr),
    .frag_count       (in_frag_count),
    .frags_per_block  (fpb_cfg_r),
    .fs_frag_count    (fsc_cfg_r),
    .skip_range_check (skip_cfg_r),
    .claim            (dec_claim),
    .even_row         (dec_even_row),
    .odd_row          (dec_odd_row)
  );

  fmdc_bank #(
    .DEPTH (BANK_DEPTH)
  ) u_bank_even (
    .clk     (clk),
    .wr_en   (even_we),
    .wr_row  (even_wrow),
    .wr_data (even_wdata),
    .rd_en   (rd_en),
    .rd_row  (dec_even_row),
    .rd_data (even_q)
  );

  fmdc_bank #(
    .DEPTH (BANK_DEPTH)
  ) u_bank_odd (
    .clk     (clk),
    .wr_en   (odd_we),
    .wr_row  (odd_wrow),
    .wr_data (odd_wdata),
    .rd_en   (rd_en),
    .rd_row  (dec_odd_row),
    .rd_data (odd_q)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fpb_cfg_r  <= fmdc_pkg::FPB_RST;
      fsc_cfg_r  <= fmdc_pkg::FSC_RST;
      skip_cfg_r <= 1'b0;
      off_cfg_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        fmdc_pkg::CFG_FRAGS_PER_BLOCK:  fpb_cfg_r  <= cfg_wdata[fmdc_pkg::FPB_W-1:0];
        fmdc_pkg::CFG_FS_FRAG_COUNT:    fsc_cfg_r  <= cfg_wdata;
        fmdc_pkg::CFG_SKIP_RANGE_CHECK: skip_cfg_r <= cfg_wdata[0];
        fmdc_pkg::CFG_DUP_CHECK_OFF:    off_cfg_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // handshake
  assign in_stall = (state_r != fmdc_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign rd_en    = in_acc && !dec_claim.bad && !off_cfg_r;
  assign finish   = (state_r == fmdc_pkg::ST_BUSY) && (!out_valid_r || !out_stall);

  // merge the fetched window with the claim
  always_comb begin
    win     = claim_r.par ? {even_q, odd_q} : {odd_q, even_q};
    used    = win & claim_r.mask;
    new_win = win | claim_r.mask;
    full    = (used == claim_r.mask);
    if (!active_r) begin
      dups = 4'd0;
      wdup = 1'b0;
      mis  = 1'b0;
    end else if (claim_r.whole) begin
      dups = full ? claim_r.fpb : 4'd0;
      wdup = full;
      mis  = claim_r.mis;
    end else begin
      dups = 4'(popcount16(used));
      wdup = 1'b0;
      mis  = 1'b0;
    end
    total_sum = {1'b0, total_r} + 33'(dups);
    total_nxt = total_sum[fmdc_pkg::TOTAL_W] ? '1 : total_sum[fmdc_pkg::TOTAL_W-1:0];
  end

  // bank write ports: clearing sweep or write back
  always_comb begin
    if (state_r == fmdc_pkg::ST_CLEAR) begin
      even_we    = 1'b1;
      odd_we     = 1'b1;
      even_wrow  = clr_cnt_r;
      odd_wrow   = clr_cnt_r;
      even_wdata = 8'd0;
      odd_wdata  = 8'd0;
    end else begin
      even_wrow  = even_row_r;
      odd_wrow   = odd_row_r;
      even_wdata = claim_r.par ? new_win[15:8] : new_win[7:0];
      odd_wdata  = claim_r.par ? new_win[7:0]  : new_win[15:8];
      even_we    = finish && active_r &&
                   ((claim_r.par ? claim_r.mask[15:8] : claim_r.mask[7:0]) != 8'd0);
      odd_we     = finish && active_r &&
                   ((claim_r.par ? claim_r.mask[7:0] : claim_r.mask[15:8]) != 8'd0);
    end
  end

  // next state
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      fmdc_pkg::ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + ROW_W'(1);
        if (clr_cnt_r == LAST_ROW) begin
          state_nxt = fmdc_pkg::ST_IDLE;
        end
      end
      fmdc_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = fmdc_pkg::ST_BUSY;
        end
      end
      fmdc_pkg::ST_BUSY: begin
        if (finish) begin
          state_nxt     = fmdc_pkg::ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = fmdc_pkg::ST_CLEAR;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fmdc_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      total_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (finish) begin
        total_r <= total_nxt;
      end
    end
  end

  // claim stage capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      claim_r    <= dec_claim;
      active_r   <= !dec_claim.bad && !off_cfg_r;
      even_row_r <= dec_even_row;
      odd_row_r  <= dec_odd_row;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (finish) begin
      bad_r  <= claim_r.bad;
      dups_r <= dups;
      wdup_r <= wdup;
      mis_r  <= mis;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_bad_address     = bad_r;
  assign out_dup_count       = dups_r;
  assign out_whole_block_dup = wdup_r;
  assign out_misaligned      = mis_r;
  assign out_total_dup       = total_r;

endmodule

>>> rtl/fmdc_bank.sv
// ----------------------------------------------------------------------------
// fmdc_bank
// Byte-wide bitmap bank: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fmdc_bank #(
  parameter int DEPTH = 4096,
  localparam int ROW_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [ROW_W-1:0] wr_row,
  input  logic [7:0]       wr_data,
  input  logic             rd_en,
  input  logic [ROW_W-1:0] rd_row,
  output logic [7:0]       rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_row];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/fmdc_decode.sv
// ----------------------------------------------------------------------------
// fmdc_decode
// Turns a claim into its fragment window, bank rows and address flags.
// ----------------------------------------------------------------------------
module fmdc_decode #(
  parameter int MAP_FRAGS = fmdc_pkg::MAP_FRAGS_DEF,
  localparam int MAP_BYTES = (MAP_FRAGS + 7) / 8,
  localparam int BANK_DEPTH = (MAP_BYTES + 1) / 2,
  localparam int ROW_W = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1
) (
  input  logic [fmdc_pkg::ADDR_W-1:0] frag_addr,
  input  logic [fmdc_pkg::CNT_W-1:0]  frag_count,
  input  logic [fmdc_pkg::FPB_W-1:0]  frags_per_block,
  input  logic [fmdc_pkg::FSC_W-1:0]  fs_frag_count,
  input  logic                        skip_range_check,
  output fmdc_pkg::claim_t            claim,
  output logic [ROW_W-1:0]            even_row,
  output logic [ROW_W-1:0]            odd_row
);

  localparam logic [fmdc_pkg::ADDR_W:0] MAP_LIM = (fmdc_pkg::ADDR_W + 1)'(MAP_FRAGS);

  logic [fmdc_pkg::FPB_W-1:0]  fpb;
  logic [fmdc_pkg::FPB_W-1:0]  fpb_m1;
  logic                        whole;
  logic [fmdc_pkg::CNT_W-1:0]  len;
  logic [fmdc_pkg::ADDR_W-1:0] first;
  logic [fmdc_pkg::ADDR_W:0]   end_sum;
  logic                        range_bad;
  logic                        map_bad;
  logic [fmdc_pkg::WIN_W:0]    run_mask;
  logic [fmdc_pkg::ADDR_W-4:0] byte_idx;
  logic [fmdc_pkg::ADDR_W-3:0] byte_inc;

  // run start and length
  always_comb begin
    fpb    = fmdc_pkg::block_size(frags_per_block);
    fpb_m1 = fpb - 4'd1;
    whole  = (frag_count == fpb);
    if (whole) begin
      len   = fpb;
      first = frag_addr & ~{20'd0, fpb_m1};
    end else begin
      len   = (frag_count > 4'd8) ? 4'd8 : frag_count;
      first = frag_addr;
    end
  end

  // address bounds
  always_comb begin
    end_sum   = {1'b0, first} + (fmdc_pkg::ADDR_W + 1)'(len);
    range_bad = !skip_range_check && (frag_addr >= {7'd0, fs_frag_count});
    map_bad   = ({1'b0, frag_addr} >= MAP_LIM) || (end_sum > MAP_LIM);
  end

  // fragment window over two adjacent bytes, and the bank rows they sit in
  always_comb begin
    run_mask = (17'd1 << len) - 17'd1;
    byte_idx = first[fmdc_pkg::ADDR_W-1:3];
    byte_inc = {1'b0, byte_idx} + 22'd1;

    claim.bad   = range_bad || map_bad;
    claim.whole = whole;
    claim.mis   = whole && ((frag_addr[2:0] & fpb_m1[2:0]) != 3'd0);
    claim.par   = byte_idx[0];
    claim.fpb   = fpb;
    claim.mask  = run_mask[fmdc_pkg::WIN_W-1:0] << first[2:0];

    odd_row  = ROW_W'(byte_idx[fmdc_pkg::ADDR_W-4:1]);
    even_row = ROW_W'(byte_inc[fmdc_pkg::ADDR_W-3:1]);
  end

endmodule

>>> rtl/fmdc_checker.sv
// ----------------------------------------------------------------------------
// fmdc_checker
// Port-level checks of the fragment map duplicate checker, bound to the top.
// ----------------------------------------------------------------------------
module fmdc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         out_bad_address,
  input logic [3:0]                   out_dup_count,
  input logic                         out_whole_block_dup,
  input logic                         out_misaligned,
  input logic [fmdc_pkg::TOTAL_W-1:0] out_total_dup
);

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid after reset");

  // a rejected claim reports nothing else
  a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_address |->
      out_dup_count == 4'd0 && !out_whole_block_dup && !out_misaligned)
    else $error("bad address word carries duplicate flags");

  // a whole-block duplicate counts its fragments
  a_wdup_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_whole_block_dup |-> out_dup_count != 4'd0)
    else $error("whole block duplicate with zero count");

  // one claim at a time: busy in the cycle after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("claim accepted while previous claim in flight");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_total_dup))
    else $error("stalled result word changed");

endmodule

bind fragment_map_duplicate_checker fmdc_checker u_fmdc_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_bad_address     (out_bad_address),
  .out_dup_count       (out_dup_count),
  .out_whole_block_dup (out_whole_block_dup),
  .out_misaligned      (out_misaligned),
  .out_total_dup       (out_total_dup)
);
